FILE: hw/rtl/sla_pkg.sv
// ----------------------------------------------------------------------------
// sla_pkg
// Shared types and constants for the shifted-luma anaglyph block.
// ----------------------------------------------------------------------------
package sla_pkg;

    localparam int PIX_W   = 24;
    localparam int LUMA_W  = 8;
    localparam int SHIFT_W = 3;
    localparam int MAC_W   = 24;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd3;

    // BT.601 weights in Q0.16
    localparam logic [15:0] LUMA_R_WT = 16'd19595;
    localparam logic [15:0] LUMA_G_WT = 16'd38470;
    localparam logic [15:0] LUMA_B_WT = 16'd7471;

    typedef logic [LUMA_W-1:0]  luma_t;
    typedef logic [PIX_W-1:0]   pixel_t;
    typedef logic [SHIFT_W-1:0] shift_t;

    // one registered input item after luma conversion
    typedef struct packed {
        luma_t luma;
        logic  last;
    } sla_item_t;

endpackage

FILE: hw/rtl/sla_luma.sv
// ----------------------------------------------------------------------------
// sla_luma
// Input stage: converts RGB to luma and holds the item in the input register.
// ----------------------------------------------------------------------------
module sla_luma (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  sla_pkg::pixel_t   in_pixel,
    input  logic              in_last,
    output logic              item_valid,
    output sla_pkg::sla_item_t item,
    input  logic              item_take
);
    import sla_pkg::*;

    logic      valid_reg;
    sla_item_t item_reg;
    logic [MAC_W-1:0] mac;
    luma_t     luma;

    // weighted sum, top byte is the truncated luma
    assign mac = MAC_W'(LUMA_R_WT) * MAC_W'(in_pixel[23:16])
               + MAC_W'(LUMA_G_WT) * MAC_W'(in_pixel[15:8])
               + MAC_W'(LUMA_B_WT) * MAC_W'(in_pixel[7:0]);
    assign luma = mac[MAC_W-1:MAC_W-LUMA_W];

    assign in_ready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            valid_reg <= 1'b1;
        end else if (item_take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg.luma <= luma;
            item_reg.last <= in_last;
        end
    end

endmodule

FILE: hw/rtl/sla_core.sv
// ----------------------------------------------------------------------------
// sla_core
// Luma window, row counters, output selection and the result register.
// ----------------------------------------------------------------------------
module sla_core #(
    parameter int MAX_SHIFT = 7
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  sla_pkg::shift_t    shift,
    input  logic               item_valid,
    input  sla_pkg::sla_item_t item,
    output logic               item_take,
    output logic               out_valid,
    input  logic               out_ready,
    output sla_pkg::pixel_t    out_pixel,
    output logic               out_row_end
);
    import sla_pkg::*;

    localparam int WIN_DEPTH = 2 * MAX_SHIFT + 1;
    localparam int IW        = $clog2(WIN_DEPTH);
    localparam int CW        = $clog2(WIN_DEPTH + 1);
    localparam int EW        = $clog2(2 * WIN_DEPTH);

    luma_t          win_reg [WIN_DEPTH];
    logic [CW-1:0]  col_reg, pend_reg;
    logic           drain_reg, flush_reg;
    logic           out_valid_reg, row_end_reg;
    pixel_t         pixel_reg;

    luma_t          win_v [WIN_DEPTH];
    logic [CW-1:0]  col_v, pend_v, k;
    logic           flush_v, out_free, active, emit, more, last_out;
    logic [EW-1:0]  s_eff, kx, lsum, rdiff;
    logic           left_ok, right_ok;
    logic [IW-1:0]  lidx, ridx, kidx;
    luma_t          left, right;

    assign s_eff = (EW'(shift) > EW'(MAX_SHIFT)) ? EW'(MAX_SHIFT) : EW'(shift);

    assign out_free  = !out_valid_reg || out_ready;
    assign item_take = item_valid && !drain_reg && out_free;
    assign active    = item_take || (drain_reg && out_free);

    // state as seen this cycle: freshly shifted on a new item, held while draining
    always_comb begin
        if (drain_reg) begin
            win_v   = win_reg;
            col_v   = col_reg;
            pend_v  = pend_reg;
            flush_v = flush_reg;
        end else begin
            win_v[0] = item.luma;
            for (int i = 1; i < WIN_DEPTH; i++) begin
                win_v[i] = win_reg[i-1];
            end
            col_v   = (col_reg < CW'(WIN_DEPTH)) ? col_reg + CW'(1) : col_reg;
            pend_v  = (pend_reg < CW'(WIN_DEPTH)) ? pend_reg + CW'(1) : pend_reg;
            flush_v = item.last;
        end
    end

    // oldest pending column sits at window index pend_v - 1
    assign k     = pend_v - CW'(1);
    assign kx    = EW'(k);
    assign kidx  = k[IW-1:0];
    assign lsum  = kx + s_eff;
    assign rdiff = kx - s_eff;

    // missing neighbor falls back to the column's own luma
    assign left_ok  = (EW'(col_v) >= lsum + EW'(1)) && (lsum < EW'(WIN_DEPTH));
    assign right_ok = (kx >= s_eff);
    assign lidx     = left_ok  ? lsum[IW-1:0]  : kidx;
    assign ridx     = right_ok ? rdiff[IW-1:0] : kidx;

    assign left  = win_v[lidx];
    assign right = win_v[ridx];

    assign emit     = active && (flush_v ? (pend_v != '0) : (EW'(pend_v) > s_eff));
    assign last_out = flush_v && (k == '0);
    assign more     = flush_v ? (k != '0) : (EW'(k) > s_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            pend_reg  <= '0;
            drain_reg <= 1'b0;
            flush_reg <= 1'b0;
        end else if (active) begin
            col_reg   <= (emit && last_out) ? '0 : col_v;
            pend_reg  <= emit ? k : pend_v;
            drain_reg <= emit && more;
            flush_reg <= flush_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take) begin
            win_reg <= win_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            pixel_reg   <= {left, 8'h00, right};
            row_end_reg <= last_out;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_pixel   = pixel_reg;
    assign out_row_end = row_end_reg;

endmodule

FILE: hw/rtl/shifted_luma_anaglyph.sv
// ----------------------------------------------------------------------------
// shifted_luma_anaglyph
// Red/cyan pseudo-anaglyph from an RGB pixel stream by horizontal luma shift.
// ----------------------------------------------------------------------------
// Each input item is one 24-bit RGB pixel in row order; last_in_row marks the
// final pixel of a row. Every pixel yields one output item whose red byte is
// the BT.601 luma (Q0.16 weights, truncated) of the pixel s columns to the
// left, green is zero, and blue is the luma s columns to the right; near a row
// edge the pixel's own luma stands in for the missing side. s is the
// shift_distance register (reset 3), clamped to MAX_SHIFT. Outputs trail the
// input by s columns inside a row. Within a row, while the output is not
// stalled, the block takes one pixel per clock and gives one result per clock
// once s+1 pixels have arrived. The last pixel of a row releases all pending
// results (up to s+1), one per clock from the result register unless stalled,
// and input is held off until they have drained. A pixel passes an input
// register (luma conversion ahead of it) and a result register: a result that
// an item releases as it is taken is presented in the cycle after the take.
// Write shift_distance only while the block is idle.
// ----------------------------------------------------------------------------
module shifted_luma_anaglyph #(
    parameter int MAX_SHIFT = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // shift_distance register
    input  logic                 cfg_we,
    input  sla_pkg::shift_t      cfg_wdata,
    // pixel input
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sla_pkg::pixel_t      s_pixel,
    input  logic                 s_last_in_row,
    // anaglyph output
    output logic                 m_valid,
    input  logic                 m_ready,
    output sla_pkg::pixel_t      m_pixel_out,
    output logic                 m_row_end_out
);
    import sla_pkg::*;

    shift_t    shift_reg;
    logic      item_valid;
    logic      item_take;
    sla_item_t item;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= SHIFT_RESET;
        end else if (cfg_we) begin
            shift_reg <= cfg_wdata;
        end
    end

    // input register with luma conversion in front
    sla_luma u_luma (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_pixel   (s_pixel),
        .in_last    (s_last_in_row),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // window, counters, neighbor selection and result register
    sla_core #(
        .MAX_SHIFT (MAX_SHIFT)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .shift       (shift_reg),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_pixel   (m_pixel_out),
        .out_row_end (m_row_end_out)
    );

endmodule

FILE: test/sla_checker.sv
// ----------------------------------------------------------------------------
// sla_checker
// Watches the pixel and anaglyph channels of shifted_luma_anaglyph, predicts
// every anaglyph item from the accepted pixels and the shift register, and
// compares the two in order.
// ----------------------------------------------------------------------------
module sla_checker #(
    parameter int MAX_SHIFT = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  sla_pkg::shift_t  cfg_wdata,
    input  logic             s_valid,
    input  logic             s_ready,
    input  sla_pkg::pixel_t  s_pixel,
    input  logic             s_last_in_row,
    input  logic             m_valid,
    input  logic             m_ready,
    input  sla_pkg::pixel_t  m_pixel_out,
    input  logic             m_row_end_out,
    output int               fail_count,
    output int               expected_left
);
    timeunit 1ns;
    timeprecision 1ps;
    import sla_pkg::*;

    localparam int HIST_DEPTH = 2 * MAX_SHIFT + 1;
    localparam int PRINT_CAP  = 40;

    typedef struct packed {
        pixel_t pix;
        logic   row_end;
    } anaglyph_t;

    luma_t     luma_hist [HIST_DEPTH];  // newest luma at index 0
    int        row_cols;                // columns of this row seen, saturating
    int        cols_owed;               // columns of this row not yet output
    shift_t    shift_cfg;
    anaglyph_t anaglyph_due [$];
    int        errs = 0;

    assign fail_count = errs;

    function automatic luma_t luma_of_rgb(pixel_t rgb);
        logic [31:0] acc;
        acc = 32'(LUMA_R_WT) * 32'(rgb[23:16]) + 32'(LUMA_G_WT) * 32'(rgb[15:8])
            + 32'(LUMA_B_WT) * 32'(rgb[7:0]);
        return acc[23:16];
    endfunction

    // output for the owed column whose luma sits at history index k
    function automatic anaglyph_t column_out(int k, int s, logic row_end);
        luma_t own;
        luma_t left;
        luma_t right;
        own   = luma_hist[k];
        left  = own;
        right = own;
        if (row_cols >= k + s + 1 && k + s < HIST_DEPTH) begin
            left = luma_hist[k + s];
        end
        if (k >= s) begin
            right = luma_hist[k - s];
        end
        return '{pix: {left, 8'h00, right}, row_end: row_end};
    endfunction

    task automatic predict_anaglyph(pixel_t rgb, logic last);
        int s;
        s = (int'(shift_cfg) > MAX_SHIFT) ? MAX_SHIFT : int'(shift_cfg);
        for (int i = HIST_DEPTH - 1; i > 0; i--) begin
            luma_hist[i] = luma_hist[i - 1];
        end
        luma_hist[0] = luma_of_rgb(rgb);
        if (row_cols < HIST_DEPTH) row_cols++;
        if (cols_owed < HIST_DEPTH) cols_owed++;
        if (last) begin
            while (cols_owed > 0) begin
                anaglyph_due.push_back(column_out(cols_owed - 1, s, cols_owed == 1));
                cols_owed--;
            end
            row_cols = 0;
        end else begin
            while (cols_owed > s) begin
                anaglyph_due.push_back(column_out(cols_owed - 1, s, 1'b0));
                cols_owed--;
            end
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errs++;
        if (errs <= PRINT_CAP) begin
            $display("sla_checker: %s at %0t ns: got %h, expected %h",
                     what, $realtime, got, want);
        end
    endtask

    always @(posedge aclk) begin
        anaglyph_t want;
        if (!aresetn) begin
            foreach (luma_hist[i]) luma_hist[i] = '0;
            row_cols  = 0;
            cols_owed = 0;
            shift_cfg = SHIFT_RESET;
            anaglyph_due.delete();
        end else begin
            if (cfg_we) shift_cfg = cfg_wdata;
            if (m_valid && m_ready) begin
                if (anaglyph_due.size() == 0) begin
                    report_mismatch("item with nothing due", 32'(m_pixel_out), '0);
                end else begin
                    want = anaglyph_due.pop_front();
                    if (m_pixel_out !== want.pix)
                        report_mismatch("pixel_out", 32'(m_pixel_out), 32'(want.pix));
                    if (m_row_end_out !== want.row_end)
                        report_mismatch("row_end_out", 32'(m_row_end_out),
                                        32'(want.row_end));
                end
            end
            if (s_valid && s_ready) predict_anaglyph(s_pixel, s_last_in_row);
        end
        expected_left <= anaglyph_due.size();
    end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the shifted_luma_anaglyph bench: clock, reset, pixel stimulus, sink
// back-pressure and the verdict. Prediction and comparison live in sla_checker.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sla_pkg::*;

    localparam int MAX_SHIFT   = 7;
    localparam int STALL_LIMIT = 2000;          // cycles with no item moving
    localparam int FLUSH_WAIT  = MAX_SHIFT + 6; // two-stage pipe plus row-end flush
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 25;

    logic   aclk          = 1'b0;
    logic   aresetn       = 1'b0;
    logic   cfg_we        = 1'b0;
    shift_t cfg_wdata     = SHIFT_RESET;
    logic   s_valid       = 1'b0;
    logic   s_ready;
    pixel_t s_pixel       = '0;
    logic   s_last_in_row = 1'b0;
    logic   m_valid;
    logic   m_ready       = 1'b0;
    pixel_t m_pixel_out;
    logic   m_row_end_out;

    int fail_count;
    int expected_left;

    // percent of cycles the source holds back / the sink refuses
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    int         pixels_sent = 0;
    int         rows_sent   = 0;
    int         pixels_got  = 0;
    int         idle_cycles = 0;
    logic [7:0] shifts_used = '0;

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    shifted_luma_anaglyph #(
        .MAX_SHIFT (MAX_SHIFT)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel       (s_pixel),
        .s_last_in_row (s_last_in_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_out   (m_pixel_out),
        .m_row_end_out (m_row_end_out)
    );

    sla_checker #(
        .MAX_SHIFT (MAX_SHIFT)
    ) i_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel       (s_pixel),
        .s_last_in_row (s_last_in_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_out   (m_pixel_out),
        .m_row_end_out (m_row_end_out),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    // Sink: ready is redrawn every cycle, independent of m_valid.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog plus result count. Any item moving on either side clears it.
    always @(posedge aclk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: no item moved for %0d cycles", STALL_LIMIT);
            $display("tb: done, errors");
            $finish;
        end else begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready) pixels_got <= pixels_got + 1;
        end
    end

    // One pixel item. Called at a rising edge; returns at the edge that takes it,
    // with valid still high so a following item can go out back to back.
    task automatic send_pixel(pixel_t rgb, logic last);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel       <= rgb;
        s_last_in_row <= last;
        do @(posedge aclk); while (!s_ready);
        pixels_sent++;
        if (last) rows_sent++;
    endtask

    // Drops valid, waits until every predicted item has come out, then lets
    // the pipe and any flush settle (an item may owe nothing yet still be inside).
    // expected_left is registered, hence the first edge before looking at it.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_left != 0) @(posedge aclk);
        repeat (FLUSH_WAIT) @(posedge aclk);
    endtask

    task automatic set_shift(shift_t shift_sel);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= shift_sel;
        shifts_used[shift_sel] = 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Each channel leans toward its extremes so saturated colors show up often.
    function automatic pixel_t rand_rgb();
        pixel_t rgb;
        for (int c = 0; c < 3; c++) begin
            case ($urandom_range(7))
                0:       rgb[c*8 +: 8] = 8'h00;
                1:       rgb[c*8 +: 8] = 8'hFF;
                default: rgb[c*8 +: 8] = 8'($urandom_range(255));
            endcase
        end
        return rgb;
    endfunction

    task automatic send_row(int len);
        for (int i = 0; i < len; i++) begin
            send_pixel(rand_rgb(), i == len - 1);
        end
    endtask

    initial begin
        int     sent;
        int     len;
        shift_t shift_sel;

        shifts_used[SHIFT_RESET] = 1'b1;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed ---
        // reset shift of 3, channel extremes: black, white, pure R, G, B
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'hFF0000, 1'b0);
        send_pixel(24'h00FF00, 1'b0);
        send_pixel(24'h0000FF, 1'b1);
        // one-pixel row, then a row shorter than the shift: own luma both sides
        send_pixel(24'hFFFFFF, 1'b1);
        send_pixel(24'h123456, 1'b0);
        send_pixel(24'hEDCBA9, 1'b1);
        // shift lowered mid-row: three columns owed at 3, all released at 0
        send_pixel(24'hA5A5A5, 1'b0);
        send_pixel(24'h5A5A5A, 1'b0);
        send_pixel(24'h808080, 1'b0);
        send_pixel(24'h7F7F7F, 1'b0);
        set_shift(3'd0);
        send_pixel(24'h010203, 1'b0);
        send_pixel(24'hFEFDFC, 1'b1);
        // widest shift, row of nine: too short for any column to have both sides
        set_shift(3'd7);
        send_row(9);

        // --- random ---
        // Four idle mixes, each twice, every phase with its own shift.
        // Rows end each phase so the checker's row state is clean for the write.
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 3) shift_sel = 3'd0;
            else if (ph == 6) shift_sel = 3'd7;
            else shift_sel = shift_t'($urandom_range(7));
            set_shift(shift_sel);
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 54; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 54; end
                default: begin src_idle_pct = 36; sink_stall_pct = 36; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                // mostly short rows; now and then one past the history depth
                if ($urandom_range(9) == 0) len = $urandom_range(40, 16);
                else len = $urandom_range(12, 1);
                send_row(len);
                sent += len;
            end
        end

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        wait_drained();

        $display("tb: %0d pixels in %0d rows sent, %0d anaglyph items checked",
                 pixels_sent, rows_sent, pixels_got);
        $display("tb: shift settings used %b (bit n = shift n), four idle/stall mixes",
                 shifts_used);
        if (fail_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/sla_pkg.sv
hw/rtl/sla_luma.sv
hw/rtl/sla_core.sv
hw/rtl/shifted_luma_anaglyph.sv
test/sla_checker.sv
test/tb.sv
